@@ src/qsh_pkg.sv @@
// ----------------------------------------------------------------------------
// qsh_pkg
// Shared types and constants of the quicksort sorter: sizes, the command and
// status bundles between controller and datapath, and their select codes.
// ----------------------------------------------------------------------------
package qsh_pkg;

    // sizes
    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int SIDX_W    = IDX_W + 2;
    localparam int STK_W     = 2 * IDX_W;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [SIDX_W-1:0] sidx_t;
    typedef logic [STK_W-1:0]         stk_t;
    typedef logic [DATA_W-1:0]        data_t;

    // element store read address source
    typedef enum logic [1:0] {
        RD_I,
        RD_J,
        RD_MID,
        RD_K
    } rd_sel_t;

    // element store write source
    typedef enum logic [1:0] {
        WR_NONE,
        WR_LOAD,
        WR_I,
        WR_J
    } wr_sel_t;

    // range stack push source
    typedef enum logic [1:0] {
        PUSH_NONE,
        PUSH_INIT,
        PUSH_LEFT,
        PUSH_RIGHT
    } push_sel_t;

    // controller to datapath
    typedef struct packed {
        wr_sel_t   wr_sel;
        logic      rd_en;
        rd_sel_t   rd_sel;
        push_sel_t push_sel;
        logic      pop;
        logic      range_load;
        logic      part_start;
        logic      pivot_load;
        logic      i_inc;
        logic      j_dec;
        logic      vali_load;
        logic      valj_load;
        logic      k_clear;
        logic      set_clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_lt2;
        logic sp_empty;
        logic range_empty;
        logic i_le_j;
        logic i_le_last;
        logic j_ge_first;
        logic lt_pivot;
        logic gt_pivot;
        logic left_push;
        logic right_push;
        logic out_end;
    } stat_t;

endpackage

@@ src/qsh_datapath.sv @@
// ----------------------------------------------------------------------------
// qsh_datapath
// Element store, range stack, partition indices and pivot, driven by the
// commands of the controller.
// ----------------------------------------------------------------------------
module qsh_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [31:0]            value,
    input  qsh_pkg::cmd_t          cmd,
    output qsh_pkg::stat_t         stat,
    output logic [31:0]            sorted_value,
    output logic                   end_of_set,
    output logic                   overflow
);

    // memories
    qsh_pkg::data_t elem_mem [qsh_pkg::MAX_ITEMS];
    qsh_pkg::stk_t  stk_mem  [qsh_pkg::MAX_ITEMS];

    // control registers
    qsh_pkg::cnt_t count_reg, count_next;
    qsh_pkg::cnt_t sp_reg, sp_next;
    qsh_pkg::cnt_t k_reg, k_next;
    logic          dropped_reg, dropped_next;
    logic          end_reg, end_next;

    // payload registers
    qsh_pkg::data_t rd_data_reg;
    qsh_pkg::stk_t  stk_rd_reg;
    qsh_pkg::idx_t  first_reg, last_reg;
    qsh_pkg::sidx_t i_reg, i_next;
    qsh_pkg::sidx_t j_reg, j_next;
    qsh_pkg::data_t pivot_reg;
    qsh_pkg::data_t val_i_reg;
    qsh_pkg::data_t val_j_reg;

    qsh_pkg::idx_t  stk_lo, stk_hi;
    qsh_pkg::idx_t  mid;
    qsh_pkg::idx_t  rd_addr;
    qsh_pkg::idx_t  wr_addr;
    qsh_pkg::data_t wr_data;
    logic           wr_en;
    qsh_pkg::idx_t  push_addr;
    qsh_pkg::stk_t  push_data;
    logic           push_en;
    qsh_pkg::sidx_t first_s, last_s;
    qsh_pkg::cnt_t  count_m1;

    assign stk_lo   = stk_rd_reg[qsh_pkg::STK_W-1:qsh_pkg::IDX_W];
    assign stk_hi   = stk_rd_reg[qsh_pkg::IDX_W-1:0];
    assign mid      = first_reg + ((last_reg - first_reg) >> 1);
    assign first_s  = qsh_pkg::sidx_t'({2'b00, first_reg});
    assign last_s   = qsh_pkg::sidx_t'({2'b00, last_reg});
    assign count_m1 = count_reg - qsh_pkg::cnt_t'(1);

    // read address select
    always_comb
    begin
        unique case (cmd.rd_sel)
            qsh_pkg::RD_I:   rd_addr = i_reg[qsh_pkg::IDX_W-1:0];
            qsh_pkg::RD_J:   rd_addr = j_reg[qsh_pkg::IDX_W-1:0];
            qsh_pkg::RD_MID: rd_addr = mid;
            qsh_pkg::RD_K:   rd_addr = k_reg[qsh_pkg::IDX_W-1:0];
            default:         rd_addr = '0;
        endcase
    end

    // write port select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = i_reg[qsh_pkg::IDX_W-1:0];
        wr_data = val_j_reg;
        unique case (cmd.wr_sel)
            qsh_pkg::WR_NONE: wr_en = 1'b0;
            qsh_pkg::WR_LOAD:
            begin
                wr_en   = (count_reg < qsh_pkg::cnt_t'(qsh_pkg::MAX_ITEMS));
                wr_addr = count_reg[qsh_pkg::IDX_W-1:0];
                wr_data = value;
            end
            qsh_pkg::WR_I:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg[qsh_pkg::IDX_W-1:0];
                wr_data = val_j_reg;
            end
            qsh_pkg::WR_J:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg[qsh_pkg::IDX_W-1:0];
                wr_data = val_i_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // stack push select
    always_comb
    begin
        push_en   = (sp_reg < qsh_pkg::cnt_t'(qsh_pkg::MAX_ITEMS));
        push_addr = sp_reg[qsh_pkg::IDX_W-1:0];
        push_data = {first_reg, j_reg[qsh_pkg::IDX_W-1:0]};
        unique case (cmd.push_sel)
            qsh_pkg::PUSH_NONE:  push_en = 1'b0;
            qsh_pkg::PUSH_INIT:  push_data = {qsh_pkg::idx_t'(0),
                                              count_m1[qsh_pkg::IDX_W-1:0]};
            qsh_pkg::PUSH_LEFT:  push_data = {first_reg, j_reg[qsh_pkg::IDX_W-1:0]};
            qsh_pkg::PUSH_RIGHT: push_data = {i_reg[qsh_pkg::IDX_W-1:0], last_reg};
            default:             push_en = 1'b0;
        endcase
    end

    // element store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            elem_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= elem_mem[rd_addr];
        end
    end

    // range stack
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stk_mem[push_addr] <= push_data;
        end
        if (cmd.pop)
        begin
            stk_rd_reg <= stk_mem[sp_next[qsh_pkg::IDX_W-1:0]];
        end
    end

    // control next state
    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        sp_next      = sp_reg;
        k_next       = k_reg;
        end_next     = end_reg;
        if (cmd.wr_sel == qsh_pkg::WR_LOAD)
        begin
            if (count_reg < qsh_pkg::cnt_t'(qsh_pkg::MAX_ITEMS))
            begin
                count_next = count_reg + qsh_pkg::cnt_t'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
        if (push_en)
        begin
            sp_next = sp_reg + qsh_pkg::cnt_t'(1);
        end
        else if (cmd.pop)
        begin
            sp_next = sp_reg - qsh_pkg::cnt_t'(1);
        end
        if (cmd.k_clear)
        begin
            k_next = '0;
        end
        else if (cmd.rd_en && cmd.rd_sel == qsh_pkg::RD_K)
        begin
            k_next   = k_reg + qsh_pkg::cnt_t'(1);
            end_next = (k_reg == count_m1);
        end
        if (cmd.set_clear)
        begin
            count_next   = '0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            sp_reg      <= '0;
            k_reg       <= '0;
            end_reg     <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            sp_reg      <= sp_next;
            k_reg       <= k_next;
            end_reg     <= end_next;
        end
    end

    // partition indices
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (cmd.part_start)
        begin
            i_next = first_s;
            j_next = last_s;
        end
        else
        begin
            if (cmd.i_inc)
            begin
                i_next = i_reg + qsh_pkg::sidx_t'(1);
            end
            if (cmd.j_dec)
            begin
                j_next = j_reg - qsh_pkg::sidx_t'(1);
            end
        end
    end

    // partition payload
    always_ff @(posedge clk)
    begin
        if (cmd.range_load)
        begin
            first_reg <= stk_lo;
            last_reg  <= stk_hi;
        end
        i_reg <= i_next;
        j_reg <= j_next;
        if (cmd.pivot_load)
        begin
            pivot_reg <= rd_data_reg;
        end
        if (cmd.vali_load)
        begin
            val_i_reg <= rd_data_reg;
        end
        if (cmd.valj_load)
        begin
            val_j_reg <= rd_data_reg;
        end
    end

    // status
    assign stat.count_lt2   = (count_reg < qsh_pkg::cnt_t'(2));
    assign stat.sp_empty    = (sp_reg == '0);
    assign stat.range_empty = (first_reg >= last_reg);
    assign stat.i_le_j      = (i_reg <= j_reg);
    assign stat.i_le_last   = (i_reg <= last_s);
    assign stat.j_ge_first  = (j_reg >= first_s);
    assign stat.lt_pivot    = ($signed(rd_data_reg) < $signed(pivot_reg));
    assign stat.gt_pivot    = ($signed(rd_data_reg) > $signed(pivot_reg));
    assign stat.left_push   = (j_reg > first_s);
    assign stat.right_push  = (i_reg < last_s);
    assign stat.out_end     = end_reg;

    // result fields
    assign sorted_value = rd_data_reg;
    assign end_of_set   = end_reg;
    assign overflow     = dropped_reg;

endmodule

@@ src/qsh_controller.sv @@
// ----------------------------------------------------------------------------
// qsh_controller
// Sequencer of load, quicksort partition passes and the result burst.
// ----------------------------------------------------------------------------
module qsh_controller
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           is_last,
    input  qsh_pkg::stat_t stat,
    output qsh_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           result_valid
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_RANGE,
        ST_PIVOT,
        ST_LOOP,
        ST_SCAN_I,
        ST_SCAN_I_CHK,
        ST_SCAN_J,
        ST_SCAN_J_CHK,
        ST_SWAP_TEST,
        ST_SWAP_J,
        ST_PUSH_L,
        ST_PUSH_R,
        ST_OUT_FIRST
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   stream_reg, stream_next;

    // next state and commands
    always_comb
    begin
        cmd               = '0;
        state_next        = state_reg;
        stream_next       = stream_reg;
        result_valid_next = 1'b0;
        if (stream_reg)
        begin
            // one result per cycle, the next read issued alongside
            if (stat.out_end)
            begin
                cmd.set_clear = 1'b1;
                stream_next   = 1'b0;
                state_next    = ST_IDLE;
            end
            else
            begin
                cmd.rd_en         = 1'b1;
                cmd.rd_sel        = qsh_pkg::RD_K;
                result_valid_next = 1'b1;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        cmd.wr_sel = qsh_pkg::WR_LOAD;
                        if (is_last)
                        begin
                            state_next = ST_SORT_INIT;
                        end
                    end
                end
                ST_SORT_INIT:
                begin
                    cmd.k_clear = 1'b1;
                    if (stat.count_lt2)
                    begin
                        state_next = ST_OUT_FIRST;
                    end
                    else
                    begin
                        cmd.push_sel = qsh_pkg::PUSH_INIT;
                        state_next   = ST_POP;
                    end
                end
                ST_POP:
                begin
                    if (stat.sp_empty)
                    begin
                        state_next = ST_OUT_FIRST;
                    end
                    else
                    begin
                        cmd.pop    = 1'b1;
                        state_next = ST_POP_WAIT;
                    end
                end
                ST_POP_WAIT:
                begin
                    cmd.range_load = 1'b1;
                    state_next     = ST_RANGE;
                end
                ST_RANGE:
                begin
                    if (stat.range_empty)
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        cmd.rd_en      = 1'b1;
                        cmd.rd_sel     = qsh_pkg::RD_MID;
                        cmd.part_start = 1'b1;
                        state_next     = ST_PIVOT;
                    end
                end
                ST_PIVOT:
                begin
                    cmd.pivot_load = 1'b1;
                    state_next     = ST_LOOP;
                end
                ST_LOOP:
                begin
                    state_next = stat.i_le_j ? ST_SCAN_I : ST_PUSH_L;
                end
                // advance i past keys below the pivot
                ST_SCAN_I:
                begin
                    if (stat.i_le_last)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = qsh_pkg::RD_I;
                        state_next = ST_SCAN_I_CHK;
                    end
                    else
                    begin
                        state_next = ST_SCAN_J;
                    end
                end
                ST_SCAN_I_CHK:
                begin
                    if (stat.lt_pivot)
                    begin
                        cmd.i_inc  = 1'b1;
                        state_next = ST_SCAN_I;
                    end
                    else
                    begin
                        cmd.vali_load = 1'b1;
                        state_next    = ST_SCAN_J;
                    end
                end
                // retreat j past keys above the pivot
                ST_SCAN_J:
                begin
                    if (stat.j_ge_first)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = qsh_pkg::RD_J;
                        state_next = ST_SCAN_J_CHK;
                    end
                    else
                    begin
                        state_next = ST_SWAP_TEST;
                    end
                end
                ST_SCAN_J_CHK:
                begin
                    if (stat.gt_pivot)
                    begin
                        cmd.j_dec  = 1'b1;
                        state_next = ST_SCAN_J;
                    end
                    else
                    begin
                        cmd.valj_load = 1'b1;
                        state_next    = ST_SWAP_TEST;
                    end
                end
                // swap: write at i, then at j
                ST_SWAP_TEST:
                begin
                    if (stat.i_le_j)
                    begin
                        cmd.wr_sel = qsh_pkg::WR_I;
                        state_next = ST_SWAP_J;
                    end
                    else
                    begin
                        state_next = ST_PUSH_L;
                    end
                end
                ST_SWAP_J:
                begin
                    cmd.wr_sel = qsh_pkg::WR_J;
                    cmd.i_inc  = 1'b1;
                    cmd.j_dec  = 1'b1;
                    state_next = ST_LOOP;
                end
                ST_PUSH_L:
                begin
                    if (stat.left_push)
                    begin
                        cmd.push_sel = qsh_pkg::PUSH_LEFT;
                    end
                    state_next = ST_PUSH_R;
                end
                ST_PUSH_R:
                begin
                    if (stat.right_push)
                    begin
                        cmd.push_sel = qsh_pkg::PUSH_RIGHT;
                    end
                    state_next = ST_POP;
                end
                ST_OUT_FIRST:
                begin
                    cmd.rd_en         = 1'b1;
                    cmd.rd_sel        = qsh_pkg::RD_K;
                    result_valid_next = 1'b1;
                    stream_next       = 1'b1;
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            stream_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            stream_reg       <= stream_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE) || stream_reg;
    assign result_valid = result_valid_reg;

endmodule

@@ src/quicksort_hoare_sorter.sv @@
// ----------------------------------------------------------------------------
// quicksort_hoare_sorter
// Collects signed values, sorts them ascending by quicksort with a Hoare
// partition around the middle element, and streams them out.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low; up to 64
// values are kept, further ones are dropped and flag overflow on the results.
// The request marked is_last starts the sort: busy stays high through it and
// through the result burst. Every step of a partition pass goes through the
// one read and one write port of the element store. Results then follow back
// to back, one per cycle, each shown for exactly one cycle with result_valid
// high and end_of_set on the last one. The receiver cannot stall the burst
// and must take every result in the cycle it appears.
// ----------------------------------------------------------------------------
module quicksort_hoare_sorter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] value,
    input  logic        is_last,
    output logic        busy,
    output logic        result_valid,
    output logic [31:0] sorted_value,
    output logic        end_of_set,
    output logic        overflow
);

    qsh_pkg::cmd_t  cmd;
    qsh_pkg::stat_t stat;

    // sequencer
    qsh_controller u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .is_last      (is_last),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    // store, stack and partition datapath
    qsh_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .cmd          (cmd),
        .stat         (stat),
        .sorted_value (sorted_value),
        .end_of_set   (end_of_set),
        .overflow     (overflow)
    );

endmodule

@@ tb/quicksort_hoare_sorter_tb.sv @@
// ----------------------------------------------------------------------------
// quicksort_hoare_sorter_tb
// Self-checking bench for the quicksort sorter. Sets of signed values are
// sent as requests with random gaps. A scoreboard keeps its own copy of the
// held values, sorts them by quicksort with a Hoare partition when the last
// request of a set is taken, and checks every value of the result burst in
// order. Covered: single values, extremes, duplicates, full and overflowing
// sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quicksort_hoare_sorter_tb;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int ITEM_TARGET   = 430;
    localparam int DRAIN_CYCLES  = 20;

    typedef logic signed [qsh_pkg::DATA_W-1:0] sval_t;

    typedef struct packed {
        qsh_pkg::data_t sorted_value;
        logic           end_of_set;
        logic           overflow;
    } sorted_result_t;

    // held values of the open set and the sorted burst still to come
    class sort_scoreboard;
        sval_t          held[qsh_pkg::MAX_ITEMS];
        int             held_count;
        logic           dropped;
        sorted_result_t expected_burst[$];
        int             errors;

        function new();
            held_count = 0;
            dropped    = 1'b0;
            errors     = 0;
        endfunction

        // quicksort over the held values, explicit range stack
        function void quicksort_hoare();
            int    lo_stack[$];
            int    hi_stack[$];
            int    first;
            int    last;
            int    i;
            int    j;
            sval_t pivot;
            sval_t tmp;
            if (held_count < 2)
                return;
            lo_stack.push_back(0);
            hi_stack.push_back(held_count - 1);
            while (lo_stack.size() > 0)
            begin
                first = lo_stack.pop_back();
                last  = hi_stack.pop_back();
                if (first >= last)
                    continue;
                pivot = held[first + (last - first) / 2];
                i = first;
                j = last;
                while (i <= j)
                begin
                    while (i <= last && held[i] < pivot)
                        i++;
                    while (j >= first && held[j] > pivot)
                        j--;
                    // equal keys are swapped too
                    if (i <= j)
                    begin
                        tmp     = held[i];
                        held[i] = held[j];
                        held[j] = tmp;
                        i++;
                        j--;
                    end
                end
                if (j > first)
                begin
                    lo_stack.push_back(first);
                    hi_stack.push_back(j);
                end
                if (i < last)
                begin
                    lo_stack.push_back(i);
                    hi_stack.push_back(last);
                end
            end
        endfunction

        // accepted request: hold the value, on the last one queue the burst
        function void note_request(qsh_pkg::data_t v, logic last);
            sorted_result_t r;
            if (held_count < qsh_pkg::MAX_ITEMS)
            begin
                held[held_count] = v;
                held_count++;
            end
            else
                dropped = 1'b1;
            if (!last)
                return;
            quicksort_hoare();
            for (int k = 0; k < held_count; k++)
            begin
                r.sorted_value = held[k];
                r.end_of_set   = (k == held_count - 1);
                r.overflow     = dropped;
                expected_burst.push_back(r);
            end
            held_count = 0;
            dropped    = 1'b0;
        endfunction

        // compare one result against the oldest expectation
        function void check_result(qsh_pkg::data_t v, logic eos, logic ovf);
            sorted_result_t r;
            if (expected_burst.size() == 0)
            begin
                $display("%0t: unexpected result sorted_value %h end_of_set %b overflow %b",
                         $time, v, eos, ovf);
                errors++;
                return;
            end
            r = expected_burst.pop_front();
            if (v !== r.sorted_value)
            begin
                $display("%0t: sorted_value expected %h, actual %h",
                         $time, r.sorted_value, v);
                errors++;
            end
            if (eos !== r.end_of_set)
            begin
                $display("%0t: end_of_set expected %b, actual %b", $time, r.end_of_set, eos);
                errors++;
            end
            if (ovf !== r.overflow)
            begin
                $display("%0t: overflow expected %b, actual %b", $time, r.overflow, ovf);
                errors++;
            end
        endfunction

        function int pending();
            return expected_burst.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic [31:0] value;
    logic        is_last;
    logic        busy;
    logic        result_valid;
    logic [31:0] sorted_value;
    logic        end_of_set;
    logic        overflow;

    sort_scoreboard board = new();
    int             cycle_count = 0;
    int             sent_count = 0;

    quicksort_hoare_sorter dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .value        (value),
        .is_last      (is_last),
        .busy         (busy),
        .result_valid (result_valid),
        .sorted_value (sorted_value),
        .end_of_set   (end_of_set),
        .overflow     (overflow)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check_result(sorted_value, end_of_set, overflow);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("quicksort_hoare_sorter regression: fail");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // full range, clustered duplicates, extremes and their neighbors
    function automatic qsh_pkg::data_t pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom;
        if (r < 8)
            return qsh_pkg::data_t'($urandom_range(0, 6) - 3);
        if (r == 8)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        if ($urandom_range(0, 1))
            return 32'h8000_0000 + $urandom_range(0, 3);
        return 32'h7fff_ffff - $urandom_range(0, 3);
    endfunction

    // one request, held until taken; start stays high across back-to-back requests
    task automatic send_request(input qsh_pkg::data_t v, input logic last, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        value   <= v;
        is_last <= last;
        do
            @(posedge clk);
        while (busy);
        board.note_request(v, last);
        sent_count++;
    endtask

    task automatic send_list(input qsh_pkg::data_t vals[$]);
        for (int k = 0; k < vals.size(); k++)
            send_request(vals[k], k == vals.size() - 1, pick_gap(1'b0));
    endtask

    task automatic send_random_set(input int n);
        bit steady;
        steady = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n; k++)
            send_request(pick_value(), k == n - 1, pick_gap(steady));
    endtask

    initial
    begin
        qsh_pkg::data_t list[$];
        int             set_no;
        int             r;
        int             n;

        rst_n   = 1'b0;
        start   = 1'b0;
        value   = '0;
        is_last = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes with duplicates
        list = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000};
        send_list(list);
        // single value sets
        list = '{32'h8000_0000};
        send_list(list);
        list = '{32'h7fff_ffff};
        send_list(list);
        // equal pair and all equal keys
        list = '{32'h0000_0005, 32'h0000_0005};
        send_list(list);
        list = '{32'hffff_fff9, 32'hffff_fff9, 32'hffff_fff9, 32'hffff_fff9};
        send_list(list);
        // already ascending, then descending
        list = '{32'hffff_fffe, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001, 32'h0000_0002};
        send_list(list);
        list = '{32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 32'h0000_0000, 32'hffff_ffff};
        send_list(list);

        // random sets: a full one, one that overflows incl. the last request, then mixed sizes
        set_no = 0;
        while (sent_count < ITEM_TARGET)
        begin
            if (set_no == 0)
                n = qsh_pkg::MAX_ITEMS;
            else if (set_no == 1)
                n = qsh_pkg::MAX_ITEMS + 2;
            else
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    n = $urandom_range(1, 12);
                else if (r == 7 || r == 8)
                    n = $urandom_range(2, qsh_pkg::MAX_ITEMS);
                else
                    n = $urandom_range(qsh_pkg::MAX_ITEMS - 4, qsh_pkg::MAX_ITEMS + 6);
            end
            send_random_set(n);
            set_no++;
        end
        start <= 1'b0;

        // drain the last burst
        while (board.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("quicksort_hoare_sorter regression: pass");
        else
            $display("quicksort_hoare_sorter regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
src/qsh_pkg.sv
src/qsh_datapath.sv
src/qsh_controller.sv
src/quicksort_hoare_sorter.sv
tb/quicksort_hoare_sorter_tb.sv
